/* hdl/assert_macros.svh */
// Assertion helpers for the wall texture column block.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/rwtc_pkg.sv */
package rwtc_pkg;

	// Largest texture edge is 64 texels, so log2 stops at 6.
	localparam int TEX_LOG2_MAX = 6;
	localparam int IDX_W = 2 * TEX_LOG2_MAX;
	localparam logic [2:0] TEX_LOG2_RESET = 3'd6;

	localparam int SCREEN_HEIGHT = 512;
	localparam int HALF_SCREEN = SCREEN_HEIGHT / 2;

	// Quotient bits of (edge << 16) / height with edge up to 2^6.
	localparam int DIV_BITS = 17 + TEX_LOG2_MAX;
	localparam int DIV_CNT_W = $clog2(DIV_BITS);

	localparam logic [31:0] SHADE_MASK = 32'h007F_7F7F;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_BEGIN = 2'd1;
	localparam logic [1:0] CMD_PIXEL = 2'd2;

	localparam logic [1:0] FACE_NORTH = 2'd0;
	localparam logic [1:0] FACE_SOUTH = 2'd1;
	localparam logic [1:0] FACE_WEST  = 2'd2;
	localparam logic [1:0] FACE_EAST  = 2'd3;

	localparam logic [0:0] REG_TEX_SIZE_LOG2 = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_MULTIPLY
	} state_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [1:0]  load_face;
		logic [11:0] load_address;
		logic [31:0] load_color;
		logic        wall_side;
		logic        ray_x_negative;
		logic        ray_y_positive;
		logic [15:0] wall_hit_fraction;
		logic [15:0] wall_height;
		logic [8:0]  first_row;
		logic [9:0]  end_row;
		logic [9:0]  column_x;
	} request_t;

	typedef struct packed {
		logic [8:0]  pixel_row;
		logic [9:0]  pixel_column;
		logic [31:0] pixel_color;
		logic        write_enable;
		logic        column_done;
	} result_t;

	typedef struct packed {
		logic load_tex;
		logic begin_col;
		logic pixel;
		logic div_step;
		logic mul_load;
		logic out_load;
	} ctl_t;

endpackage

/* hdl/rwtc_datapath.sv */
module rwtc_datapath #(
	parameter int MAX_TEXTURE_EDGE = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         tex_log2,
	input  rwtc_pkg::request_t request,
	input  rwtc_pkg::ctl_t     ctl,
	output rwtc_pkg::result_t  result
);

	localparam int FACE_TEXELS = MAX_TEXTURE_EDGE * MAX_TEXTURE_EDGE;
	localparam int TEXEL_DEPTH = 4 * FACE_TEXELS;
	localparam int AW = $clog2(TEXEL_DEPTH);
	localparam int TW = rwtc_pkg::TEX_LOG2_MAX;
	localparam int DB = rwtc_pkg::DIV_BITS;
	localparam int IDX_W_L = rwtc_pkg::IDX_W;

	logic [2:0]    lg;
	logic [6:0]    edge_len;
	logic [TW-1:0] edge_mask;

	// Column state.
	logic [1:0]    face_q;
	logic [TW-1:0] texel_col_q;
	logic [DB-1:0] step_q;
	logic [31:0]   pos_q;
	logic [9:0]    cur_row_q;
	logic [9:0]    stop_row_q;
	logic [9:0]    col_q;

	// Divider and multiplier working registers.
	logic [15:0]        height_q;
	logic [15:0]        rem_q;
	logic [DB-1:0]      dividend_q;
	logic signed [17:0] offset_q;

	logic [1:0]         face_next;
	logic [15:0]        tx_full;
	logic [TW-1:0]      tx;
	logic [TW-1:0]      tx_col;
	logic [15:0]        height_fix;
	logic signed [17:0] offset_next;
	logic [16:0]        trial;
	logic               trial_ge;
	logic signed [DB+18:0] product;

	logic                 in_span;
	logic [TW-1:0]        ty;
	logic [IDX_W_L-1:0]   idx;
	logic                 idx_ok;
	logic                 wr_ok;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;

	logic [31:0] mem [TEXEL_DEPTH];

	// Stage one: texel read in flight.
	logic [31:0] texel_s1;
	logic [8:0]  row_s1;
	logic [9:0]  col_s1;
	logic        hit_s1;
	logic        shade_s1;
	logic        done_s1;

	logic [31:0] raw_color;
	logic [31:0] shaded;
	rwtc_pkg::result_t result_q;

	assign lg = (tex_log2 > 3'(rwtc_pkg::TEX_LOG2_MAX)) ?
		3'(rwtc_pkg::TEX_LOG2_MAX) : tex_log2;
	assign edge_len = 7'(1) << lg;
	assign edge_mask = TW'(edge_len - 7'd1);

	always_comb begin
		if (request.wall_side) begin
			face_next = request.ray_y_positive ? rwtc_pkg::FACE_SOUTH : rwtc_pkg::FACE_NORTH;
		end else begin
			face_next = request.ray_x_negative ? rwtc_pkg::FACE_WEST : rwtc_pkg::FACE_EAST;
		end
	end

	assign tx_full = request.wall_hit_fraction >> (5'd16 - 5'(lg));
	assign tx = TW'(tx_full);
	assign tx_col = (face_next == rwtc_pkg::FACE_WEST || face_next == rwtc_pkg::FACE_SOUTH) ?
		TW'(edge_mask - tx) : tx;

	assign height_fix = (request.wall_height == 16'd0) ? 16'd1 : request.wall_height;
	assign offset_next = 18'(request.first_row) + 18'(height_fix[15:1]) -
		18'(rwtc_pkg::HALF_SCREEN);

	// One quotient bit per step of the restoring divider.
	assign trial = {rem_q, dividend_q[DB-1]};
	assign trial_ge = trial >= {1'b0, height_q};
	assign product = offset_q * $signed({1'b0, step_q});

	assign in_span = cur_row_q < stop_row_q;
	assign ty = pos_q[16 +: TW] & edge_mask;
	assign idx = (IDX_W_L'(ty) << lg) + IDX_W_L'(texel_col_q);
	assign idx_ok = 32'(idx) < 32'(FACE_TEXELS);
	assign rd_addr = AW'(32'(face_q) * 32'(FACE_TEXELS) + 32'(idx));
	assign wr_ok = 32'(request.load_address) < 32'(FACE_TEXELS);
	assign wr_addr = AW'(32'(request.load_face) * 32'(FACE_TEXELS) + 32'(request.load_address));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_q      <= '0;
			texel_col_q <= '0;
			step_q      <= '0;
			pos_q       <= '0;
			cur_row_q   <= '0;
			stop_row_q  <= '0;
			col_q       <= '0;
		end else begin
			if (ctl.begin_col) begin
				face_q      <= face_next;
				texel_col_q <= tx_col;
				step_q      <= '0;
				cur_row_q   <= 10'(request.first_row);
				stop_row_q  <= request.end_row;
				col_q       <= request.column_x;
			end
			if (ctl.div_step) begin
				step_q <= {step_q[DB-2:0], trial_ge};
			end
			if (ctl.mul_load) begin
				pos_q <= product[31:0];
			end
			if (ctl.pixel && in_span) begin
				pos_q     <= pos_q + 32'(step_q);
				cur_row_q <= cur_row_q + 10'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.begin_col) begin
			height_q   <= height_fix;
			offset_q   <= offset_next;
			rem_q      <= '0;
			dividend_q <= {{(DB-1){1'b0}}, 1'b1} << (5'd16 + 5'(lg));
		end
		if (ctl.div_step) begin
			rem_q      <= trial_ge ? 16'(trial - {1'b0, height_q}) : trial[15:0];
			dividend_q <= dividend_q << 1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_tex && wr_ok) begin
			mem[wr_addr] <= request.load_color;
		end
		if (ctl.pixel && in_span && idx_ok) begin
			texel_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pixel) begin
			row_s1   <= cur_row_q[8:0];
			col_s1   <= col_q;
			hit_s1   <= in_span && idx_ok;
			shade_s1 <= (face_q == rwtc_pkg::FACE_NORTH) || (face_q == rwtc_pkg::FACE_EAST);
			done_s1  <= !in_span || ((11'(cur_row_q) + 11'd1) >= 11'(stop_row_q));
		end
	end

	assign raw_color = hit_s1 ? texel_s1 : 32'd0;
	assign shaded = shade_s1 ? ((raw_color >> 1) & rwtc_pkg::SHADE_MASK) : raw_color;

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			result_q.pixel_row    <= row_s1;
			result_q.pixel_column <= col_s1;
			result_q.pixel_color  <= shaded;
			result_q.write_enable <= (shaded != 32'd0) && !shaded[31];
			result_q.column_done  <= done_s1;
		end
	end

	assign result = result_q;

endmodule

/* hdl/rwtc_ctrl.sv */
`include "assert_macros.svh"

module rwtc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           request_valid,
	input  logic [1:0]     cmd,
	output logic           request_stall,
	output logic           result_valid,
	input  logic           result_stall,
	output rwtc_pkg::ctl_t ctl
);

	rwtc_pkg::state_t state_q;
	rwtc_pkg::state_t state_d;
	logic [rwtc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [rwtc_pkg::DIV_CNT_W-1:0] cnt_d;
	logic s1_valid_q;
	logic result_valid_q;
	logic s1_adv;
	logic fire;
	logic begin_fire;

	assign s1_adv = s1_valid_q && (!result_valid_q || !result_stall);
	assign request_stall = (state_q != rwtc_pkg::ST_IDLE) || (s1_valid_q && !s1_adv);
	assign fire = request_valid && !request_stall;
	assign begin_fire = fire && (cmd == rwtc_pkg::CMD_BEGIN);
	assign result_valid = result_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			rwtc_pkg::ST_IDLE: begin
				if (begin_fire) begin
					state_d = rwtc_pkg::ST_DIVIDE;
					cnt_d   = rwtc_pkg::DIV_CNT_W'(rwtc_pkg::DIV_BITS - 1);
				end
			end
			rwtc_pkg::ST_DIVIDE: begin
				if (cnt_q == '0) begin
					state_d = rwtc_pkg::ST_MULTIPLY;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			rwtc_pkg::ST_MULTIPLY: begin
				state_d = rwtc_pkg::ST_IDLE;
			end
			default: begin
				state_d = rwtc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl           = '0;
		ctl.load_tex  = fire && (cmd == rwtc_pkg::CMD_LOAD);
		ctl.begin_col = begin_fire;
		ctl.pixel     = fire && (cmd == rwtc_pkg::CMD_PIXEL);
		ctl.out_load  = s1_adv;
		unique case (state_q)
			rwtc_pkg::ST_DIVIDE:   ctl.div_step = 1'b1;
			rwtc_pkg::ST_MULTIPLY: ctl.mul_load = 1'b1;
			default:               ctl.div_step = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= rwtc_pkg::ST_IDLE;
			cnt_q          <= '0;
			s1_valid_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			cnt_q          <= cnt_d;
			s1_valid_q     <= ctl.pixel || (s1_valid_q && !s1_adv);
			result_valid_q <= s1_adv || (result_valid_q && result_stall);
		end
	end

	`ASSERT_NEXT(a_begin_divides, clk, arst_n, begin_fire, state_q == rwtc_pkg::ST_DIVIDE, "begin item did not start the divider")
	`ASSERT_NEXT(a_divide_ends, clk, arst_n, (state_q == rwtc_pkg::ST_DIVIDE) && (cnt_q == '0), state_q == rwtc_pkg::ST_MULTIPLY, "divider did not hand over to the multiply step")
	`ASSERT_NEXT(a_s1_held, clk, arst_n, s1_valid_q && result_valid_q && result_stall, s1_valid_q && result_valid_q, "pending pixel lost while output stalled")
	`ASSERT_IMPLIES(a_result_from_s1, clk, arst_n, $rose(result_valid_q), $past(s1_valid_q), "result appeared without a pixel in flight")

endmodule

/* hdl/raycast_wall_texture_column_core.sv */
// Textured wall column for a grid raycaster.
// Items arrive on the request channel (request_valid / request_stall) and
// results leave on the result channel (result_valid / result_stall); an item
// moves at a clock edge with valid high and stall low.
// A load item writes one texel of one of four face textures.
// A begin item selects the face and texel column and starts the row step
// computation: a one-bit-per-cycle restoring divider and then a multiply for
// the start position; no further item is accepted until both are done.
// A next-pixel item gives one result through the texture memory read and
// then the output register. Pixel items stream at one per cycle while the
// result side does not stall.
// When the receiver stalls, the result register holds its item and one more
// pixel may wait in the read stage; after that request_stall goes high.
// Reset clears the column state, both pipeline valid flags and the texture
// size register (back to edge 64); the result data itself is not reset.
// Texture memory contents are undefined until loaded. The texture size
// register sits at APB byte address 0.
module raycast_wall_texture_column_core #(
	parameter int MAX_TEXTURE_EDGE = 64
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               request_valid,
	output logic               request_stall,
	input  rwtc_pkg::request_t request,

	output logic               result_valid,
	input  logic               result_stall,
	output rwtc_pkg::result_t  result,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	rwtc_pkg::ctl_t ctl;
	logic [2:0]     tex_log2_q;
	logic           cfg_write;

	// The APB port has no wait states. Only the word index bit of the
	// address is decoded; one register exists.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_log2_q <= rwtc_pkg::TEX_LOG2_RESET;
		end else if (cfg_write && (paddr[2] == rwtc_pkg::REG_TEX_SIZE_LOG2)) begin
			tex_log2_q <= pwdata[2:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			rwtc_pkg::REG_TEX_SIZE_LOG2: prdata = {29'd0, tex_log2_q};
			default:                     prdata = 32'd0;
		endcase
	end

	// The controller sequences the divider and tracks which pipeline
	// stages hold a pixel; the datapath holds the column state, the
	// texture memory and the result register.
	rwtc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.cmd           (request.cmd),
		.request_stall (request_stall),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.ctl           (ctl)
	);

	rwtc_datapath #(
		.MAX_TEXTURE_EDGE (MAX_TEXTURE_EDGE)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.tex_log2 (tex_log2_q),
		.request  (request),
		.ctl      (ctl),
		.result   (result)
	);

endmodule

/* tb/sv/raycast_wall_texture_column_core_tb.sv */
module raycast_wall_texture_column_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The limit leaves room for the whole run, with every pixel item waiting out
	// long receiver stalls.
	localparam int CYCLE_LIMIT = 500000;
	// A begin item keeps the block busy without producing a pixel, so we wait
	// this long before touching the register or finishing.
	localparam int DRAIN_CYCLES = 40;
	localparam int ITEMS_PER_SEG = 250;
	localparam int MAX_SHOWN = 100;
	localparam int HOLD_CYCLES = 300;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam logic [2:0] SIZE_ADDR = {rwtc_pkg::REG_TEX_SIZE_LOG2, 2'b00};

	typedef struct {
		rwtc_pkg::request_t req;
		bit                 typed;
		rwtc_pkg::result_t  want;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               request_valid;
	logic               request_stall;
	rwtc_pkg::request_t request;
	logic               result_valid;
	logic               result_stall;
	rwtc_pkg::result_t  result;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	// Shadow copy of the block's column state, used to predict every pixel.
	logic [31:0] tex_mem [0:16383];
	bit          tex_written [0:16383];
	logic [1:0]  col_face;
	logic [5:0]  col_texel_x;
	logic [31:0] row_step_q;
	logic [31:0] tex_pos;
	logic [9:0]  cur_row;
	logic [9:0]  stop_row;
	logic [9:0]  cur_col;
	logic [2:0]  size_log2;

	// Pixels predicted but not yet seen on the result channel, oldest first.
	rwtc_pkg::result_t pending_pixels[$];

	int mismatches = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int size_plan[6] = '{0, 7, 3, 6, 1, 4};

	stim_row_t directed[$];

	raycast_wall_texture_column_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.request_valid(request_valid),
		.request_stall(request_stall),
		.request      (request),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #1 clk = ~clk;

	// Hard stop in case the block hangs or drops a handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** raycast_wall_texture_column_core: FAILED **");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_SHOWN)
			$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Register values above 6 behave like 6.
	function automatic int tex_lg();
		return (size_log2 > rwtc_pkg::TEX_LOG2_MAX) ? rwtc_pkg::TEX_LOG2_MAX :
			int'(size_log2);
	endfunction

	// Works out which store entry the next pixel item would read, and whether
	// it reads one at all (only while the span still has rows left).
	function automatic void texel_lookup(output bit reads, output logic [13:0] addr);
		int lg;
		logic [31:0] ty;
		logic [31:0] idx;
		lg = tex_lg();
		ty = {16'd0, tex_pos[31:16]} & ((32'd1 << lg) - 32'd1);
		idx = (ty << lg) + {26'd0, col_texel_x};
		addr = {col_face, idx[11:0]};
		reads = cur_row < stop_row;
	endfunction

	// Applies one accepted item to the shadow state. Returns 1 with the
	// predicted pixel when the item is a next-pixel command.
	function automatic bit column_step(input rwtc_pkg::request_t r,
			output rwtc_pkg::result_t px);
		int lg;
		int off;
		logic [31:0] tex_w;
		logic [31:0] tx;
		logic [15:0] h;
		logic [31:0] color;
		logic [13:0] addr;
		bit reads;
		px = '0;
		lg = tex_lg();
		tex_w = 32'd1 << lg;
		case (r.cmd)
			rwtc_pkg::CMD_LOAD: begin
				tex_mem[{r.load_face, r.load_address}] = r.load_color;
				tex_written[{r.load_face, r.load_address}] = 1'b1;
			end
			rwtc_pkg::CMD_BEGIN: begin
				if (!r.wall_side)
					col_face = r.ray_x_negative ? rwtc_pkg::FACE_WEST : rwtc_pkg::FACE_EAST;
				else
					col_face = r.ray_y_positive ? rwtc_pkg::FACE_SOUTH : rwtc_pkg::FACE_NORTH;
				// Texel column is the top lg bits of the hit fraction, mirrored
				// on the faces seen from behind.
				tx = {16'd0, r.wall_hit_fraction} >> (16 - lg);
				if (col_face == rwtc_pkg::FACE_WEST || col_face == rwtc_pkg::FACE_SOUTH)
					tx = tex_w - tx - 32'd1;
				col_texel_x = tx[5:0];
				h = (r.wall_height == 16'd0) ? 16'd1 : r.wall_height;
				row_step_q = (tex_w << 16) / {16'd0, h};
				// The start offset can be negative; the product wraps in 32 bits.
				off = int'(r.first_row) - rwtc_pkg::HALF_SCREEN + int'(h >> 1);
				tex_pos = 32'(off) * row_step_q;
				cur_row = {1'b0, r.first_row};
				stop_row = r.end_row;
				cur_col = r.column_x;
			end
			rwtc_pkg::CMD_PIXEL: begin
				texel_lookup(reads, addr);
				color = 32'd0;
				px.pixel_row = cur_row[8:0];
				px.pixel_column = cur_col;
				if (reads) begin
					tex_pos = tex_pos + row_step_q;
					color = tex_mem[addr];
					if (col_face == rwtc_pkg::FACE_NORTH || col_face == rwtc_pkg::FACE_EAST)
						color = (color >> 1) & rwtc_pkg::SHADE_MASK;
					cur_row = cur_row + 10'd1;
				end
				px.pixel_color = color;
				px.write_enable = reads && color != 32'd0 && !color[31];
				// A used-up or empty span still answers, flagged as done.
				px.column_done = !reads || cur_row >= stop_row;
				return 1'b1;
			end
			default: begin
			end
		endcase
		return 1'b0;
	endfunction

	function automatic rwtc_pkg::request_t random_request();
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		return raw[$bits(rwtc_pkg::request_t)-1:0];
	endfunction

	// Colors lean toward zero and negative words so that the write flag is
	// exercised in both directions.
	function automatic logic [31:0] random_color();
		case ($urandom_range(4))
			0: return 32'd0;
			1: return $urandom | 32'h8000_0000;
			2: return 32'($urandom_range(1, 255));
			default: return $urandom;
		endcase
	endfunction

	function automatic rwtc_pkg::request_t texel_load(input logic [1:0] face,
			input logic [11:0] addr, input logic [31:0] color);
		rwtc_pkg::request_t r;
		r = random_request();
		r.cmd = rwtc_pkg::CMD_LOAD;
		r.load_face = face;
		r.load_address = addr;
		r.load_color = color;
		return r;
	endfunction

	function automatic rwtc_pkg::request_t column_begin(input logic side, input logic xneg,
			input logic ypos, input logic [15:0] frac, input logic [15:0] height,
			input logic [8:0] first, input logic [9:0] last, input logic [9:0] colx);
		rwtc_pkg::request_t r;
		r = random_request();
		r.cmd = rwtc_pkg::CMD_BEGIN;
		r.wall_side = side;
		r.ray_x_negative = xneg;
		r.ray_y_positive = ypos;
		r.wall_hit_fraction = frac;
		r.wall_height = height;
		r.first_row = first;
		r.end_row = last;
		r.column_x = colx;
		return r;
	endfunction

	// Every other field carries noise, which the block has to ignore.
	function automatic rwtc_pkg::request_t command_item(input logic [1:0] cmd);
		rwtc_pkg::request_t r;
		r = random_request();
		r.cmd = cmd;
		return r;
	endfunction

	// Offers one item, optionally after a random idle gap, and waits for the
	// handshake. The shadow state moves only once the block has taken the item.
	task automatic drive_item(input rwtc_pkg::request_t r, input bit typed,
			input rwtc_pkg::result_t want);
		rwtc_pkg::result_t px;
		bit has_px;
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			request_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		request_valid <= 1'b1;
		request <= r;
		@(posedge clk);
		while (request_stall)
			@(posedge clk);
		has_px = column_step(r, px);
		if (has_px)
			pending_pixels.push_back(typed ? want : px);
		if (r.cmd != CMD_UNKNOWN)
			items_sent++;
	endtask

	// The texture store is undefined until written, so a pixel that would read
	// a fresh entry is preceded by a load of that entry.
	task automatic issue(input rwtc_pkg::request_t r, input bit typed,
			input rwtc_pkg::result_t want);
		logic [13:0] addr;
		bit reads;
		if (r.cmd == rwtc_pkg::CMD_PIXEL) begin
			texel_lookup(reads, addr);
			if (reads && !tex_written[addr])
				drive_item(texel_load(addr[13:12], addr[11:0], random_color()), 1'b0, '0);
		end
		drive_item(r, typed, want);
	endtask

	task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Changes the texture size only once the block has gone quiet, then reads
	// the register back.
	task automatic set_texture_size(input logic [2:0] v);
		logic [31:0] rd;
		request_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		apb_access(1'b1, SIZE_ADDR, {29'd0, v}, rd);
		apb_access(1'b0, SIZE_ADDR, 32'd0, rd);
		if (rd[2:0] !== v)
			report_mismatch($sformatf("texture size reads %0d, wrote %0d", rd[2:0], v));
		size_log2 = v;
	endtask

	// Receiver side: random stalls, or a long hold-off when one is requested,
	// so the block backs up and has to stall its own input.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Every pixel taken from the block is checked against the oldest
	// prediction, field by field.
	always @(posedge clk) begin : watch_pixels
		rwtc_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("pixel with nothing expected: %h", result));
			end else begin
				want = pending_pixels.pop_front();
				if (result.pixel_row !== want.pixel_row)
					report_mismatch($sformatf("pixel_row %0d, expected %0d",
						result.pixel_row, want.pixel_row));
				if (result.pixel_column !== want.pixel_column)
					report_mismatch($sformatf("pixel_column %0d, expected %0d",
						result.pixel_column, want.pixel_column));
				if (result.pixel_color !== want.pixel_color)
					report_mismatch($sformatf("pixel_color %h, expected %h",
						result.pixel_color, want.pixel_color));
				if (result.write_enable !== want.write_enable)
					report_mismatch($sformatf("write_enable %b, expected %b",
						result.write_enable, want.write_enable));
				if (result.column_done !== want.column_done)
					report_mismatch($sformatf("column_done %b, expected %b",
						result.column_done, want.column_done));
			end
		end
	end

	initial begin : stimulus
		rwtc_pkg::request_t r;
		int seg;
		int base;
		int span;
		int npix;
		int pick;
		bit hold_done;

		arst_n = 1'b0;
		request_valid = 1'b0;
		request = '0;
		result_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		col_face = rwtc_pkg::FACE_NORTH;
		col_texel_x = '0;
		row_step_q = '0;
		tex_pos = '0;
		cur_row = '0;
		stop_row = '0;
		cur_col = '0;
		size_log2 = rwtc_pkg::TEX_LOG2_RESET;
		hold_done = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at the reset edge of 64 texels. Expected pixels are
		// written out only where they follow directly from reset or from an
		// empty span; all others come from the shadow state.
		directed.push_back('{command_item(rwtc_pkg::CMD_PIXEL), 1'b1,
			rwtc_pkg::result_t'{pixel_row: 9'd0, pixel_column: 10'd0, pixel_color: 32'd0,
				write_enable: 1'b0, column_done: 1'b1}});
		directed.push_back('{command_item(CMD_UNKNOWN), 1'b0, '0});
		directed.push_back('{texel_load(rwtc_pkg::FACE_NORTH, 12'd0, 32'hFFFF_FFFF), 1'b0, '0});
		directed.push_back('{texel_load(rwtc_pkg::FACE_EAST, 12'd4095, 32'h8000_0000), 1'b0,
			'0});
		directed.push_back('{texel_load(rwtc_pkg::FACE_SOUTH, 12'd0, 32'h7FFF_FFFF), 1'b0, '0});
		directed.push_back('{texel_load(rwtc_pkg::FACE_WEST, 12'd63, 32'h0000_0001), 1'b0, '0});
		directed.push_back('{texel_load(rwtc_pkg::FACE_NORTH, 12'd1, 32'd0), 1'b0, '0});
		// North face, smallest height: the step is the whole texture edge.
		directed.push_back('{column_begin(1'b1, 1'b0, 1'b0, 16'h0000, 16'd1, 9'd0, 10'd1,
			10'd0), 1'b0, '0});
		directed.push_back('{command_item(rwtc_pkg::CMD_PIXEL), 1'b0, '0});
		directed.push_back('{command_item(rwtc_pkg::CMD_PIXEL), 1'b0, '0});
		// East face, full fraction and a zero height that behaves like one.
		directed.push_back('{column_begin(1'b0, 1'b0, 1'b1, 16'hFFFF, 16'd0, 9'd511, 10'd512,
			10'd1023), 1'b0, '0});
		directed.push_back('{command_item(rwtc_pkg::CMD_PIXEL), 1'b0, '0});
		directed.push_back('{command_item(rwtc_pkg::CMD_PIXEL), 1'b0, '0});
		// West face, mirrored column, tallest wall.
		directed.push_back('{column_begin(1'b0, 1'b1, 1'b0, 16'h0000, 16'hFFFF, 9'd0, 10'd512,
			10'd0), 1'b0, '0});
		directed.push_back('{command_item(rwtc_pkg::CMD_PIXEL), 1'b0, '0});
		directed.push_back('{command_item(rwtc_pkg::CMD_PIXEL), 1'b0, '0});
		// South face, mirrored, two rows then one past the end of the span.
		directed.push_back('{column_begin(1'b1, 1'b1, 1'b1, 16'h8000, 16'd2, 9'd255, 10'd257,
			10'd512), 1'b0, '0});
		directed.push_back('{command_item(rwtc_pkg::CMD_PIXEL), 1'b0, '0});
		directed.push_back('{command_item(rwtc_pkg::CMD_PIXEL), 1'b0, '0});
		directed.push_back('{command_item(rwtc_pkg::CMD_PIXEL), 1'b0, '0});
		// An empty span answers at once with its first row, flagged done.
		directed.push_back('{column_begin(1'b1, 1'b0, 1'b0, 16'h1234, 16'd64, 9'd100, 10'd100,
			10'd1023), 1'b0, '0});
		directed.push_back('{command_item(rwtc_pkg::CMD_PIXEL), 1'b1,
			rwtc_pkg::result_t'{pixel_row: 9'd100, pixel_column: 10'd1023, pixel_color: 32'd0,
				write_enable: 1'b0, column_done: 1'b1}});
		// Span whose end lies below its start.
		directed.push_back('{column_begin(1'b0, 1'b0, 1'b0, 16'h4000, 16'd300, 9'd300, 10'd0,
			10'd5), 1'b0, '0});
		directed.push_back('{command_item(rwtc_pkg::CMD_PIXEL), 1'b0, '0});

		foreach (directed[i])
			issue(directed[i].req, directed[i].typed, directed[i].want);

		// Random part in six segments, each at its own texture size. The first
		// two idle mostly on the receiver, the next two mostly on the sender,
		// the last two not at all but for one long receiver hold-off.
		for (seg = 0; seg < 6; seg++) begin
			set_texture_size(3'(size_plan[seg]));
			tx_idle_pct = (seg < 2) ? 31 : (seg < 4) ? 86 : 0;
			rx_idle_pct = (seg < 2) ? 86 : (seg < 4) ? 31 : 0;
			base = items_sent;
			while (items_sent - base < ITEMS_PER_SEG) begin
				// Once, hold the receiver off while items keep coming in.
				if (seg == 4 && !hold_done && items_sent - base > 60) begin
					hold_request = HOLD_CYCLES;
					hold_done = 1'b1;
				end
				pick = $urandom_range(99);
				r = random_request();
				if (pick < 70) begin
					// A well-formed column: begin, then roughly one pixel per row of the span,
					// for up to 24 rows, sometimes running past its end.
					r.cmd = rwtc_pkg::CMD_BEGIN;
					case ($urandom_range(3))
						0: r.wall_height = 16'($urandom_range(0, 3));
						1: r.wall_height = 16'($urandom_range(1, 700));
						default: begin
						end
					endcase
					if ($urandom_range(7) != 0)
						r.end_row = 10'(r.first_row) + 10'($urandom_range(0, 24));
					issue(r, 1'b0, '0);
					span = (r.end_row > r.first_row) ?
						int'(r.end_row) - int'(r.first_row) : 0;
					npix = ((span > 24) ? 24 : span) + $urandom_range(0, 2);
					for (int k = 0; k < npix; k++) begin
						if ($urandom_range(9) == 0)
							issue(texel_load(2'($urandom), 12'($urandom), random_color()),
								1'b0, '0);
						issue(command_item(rwtc_pkg::CMD_PIXEL), 1'b0, '0);
					end
				end else if (pick < 85) begin
					r.cmd = rwtc_pkg::CMD_LOAD;
					r.load_color = random_color();
					if ($urandom_range(1) != 0)
						r.load_address = 12'($urandom_range(0, (1 << (2 * tex_lg())) - 1));
					issue(r, 1'b0, '0);
				end else if (pick < 92) begin
					r.cmd = rwtc_pkg::CMD_PIXEL;
					issue(r, 1'b0, '0);
				end else begin
					r.cmd = CMD_UNKNOWN;
					issue(r, 1'b0, '0);
				end
			end
		end

		request_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** raycast_wall_texture_column_core: PASSED **");
		else
			$display("** raycast_wall_texture_column_core: FAILED **");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/rwtc_pkg.sv
hdl/rwtc_datapath.sv
hdl/rwtc_ctrl.sv
hdl/raycast_wall_texture_column_core.sv
tb/sv/raycast_wall_texture_column_core_tb.sv
